@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge.
`define QVR_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on the rising clock edge.
`define QVR_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ hw/rtl/qvr_pkg.sv @@
package qvr_pkg;

  // Quaternion components are signed Q1.QUAT_FRAC_BITS.
  localparam int QUAT_FRAC_BITS = 30;

  localparam int Q_W   = 32;
  localparam int V_W   = 32;
  localparam int OUT_W = 32;

  localparam int NUM_Q = 4;
  localparam int NUM_V = 3;

  // Stage one: q * (0,v), three products per component.
  localparam int P1_TERMS = 3;
  localparam int PROD1_W  = Q_W + V_W;
  localparam int SUM1_W   = PROD1_W + 2;
  localparam int P_W      = SUM1_W - QUAT_FRAC_BITS;

  // Stage two: p * conj(q), four products per vector component, each split in two halves.
  localparam int P2_TERMS = 4;
  localparam int PLO_W    = P_W / 2;
  localparam int PHI_W    = P_W - PLO_W;
  localparam int PPL_W    = PLO_W + 1 + Q_W;
  localparam int PPH_W    = PHI_W + Q_W;
  localparam int PROD2_W  = P_W + Q_W;
  localparam int SUM2_W   = PROD2_W + 2;
  localparam int R_W      = SUM2_W - QUAT_FRAC_BITS;

  // Pipeline stage positions.
  localparam int ST_PROD1   = 0;
  localparam int ST_SUM1    = 1;
  localparam int ST_PROD2   = 2;
  localparam int ST_MERGE   = 3;
  localparam int ST_SUM2    = 4;
  localparam int ST_SAT     = 5;
  localparam int NUM_STAGES = 6;

  // Component indices.
  localparam logic [1:0] QI_W = 2'd0;
  localparam logic [1:0] QI_X = 2'd1;
  localparam logic [1:0] QI_Y = 2'd2;
  localparam logic [1:0] QI_Z = 2'd3;
  localparam logic [1:0] VI_X = 2'd0;
  localparam logic [1:0] VI_Y = 2'd1;
  localparam logic [1:0] VI_Z = 2'd2;

  localparam logic TERM_ADD = 1'b0;
  localparam logic TERM_SUB = 1'b1;

  typedef logic signed [Q_W-1:0]     quat_t;
  typedef logic signed [V_W-1:0]     vec_t;
  typedef logic signed [OUT_W-1:0]   out_t;
  typedef logic signed [PROD1_W-1:0] prod1_t;
  typedef logic signed [SUM1_W-1:0]  sum1_t;
  typedef logic signed [P_W-1:0]     pval_t;
  typedef logic signed [PPL_W-1:0]   pplo_t;
  typedef logic signed [PPH_W-1:0]   pphi_t;
  typedef logic signed [PROD2_W-1:0] prod2_t;
  typedef logic signed [SUM2_W-1:0]  sum2_t;
  typedef logic signed [R_W-1:0]     rval_t;

  localparam sum1_t HALF1 = sum1_t'(1) <<< (QUAT_FRAC_BITS - 1);
  localparam sum2_t HALF2 = sum2_t'(1) <<< (QUAT_FRAC_BITS - 1);

  // Stage one terms, grouped by component of p (w, x, y, z).
  localparam logic [1:0] P1_QSEL [NUM_Q*P1_TERMS] = '{
    QI_X, QI_Y, QI_Z,
    QI_W, QI_Y, QI_Z,
    QI_W, QI_Z, QI_X,
    QI_W, QI_X, QI_Y
  };
  localparam logic [1:0] P1_VSEL [NUM_Q*P1_TERMS] = '{
    VI_X, VI_Y, VI_Z,
    VI_X, VI_Z, VI_Y,
    VI_Y, VI_X, VI_Z,
    VI_Z, VI_Y, VI_X
  };
  localparam logic P1_NEG [NUM_Q*P1_TERMS] = '{
    TERM_SUB, TERM_SUB, TERM_SUB,
    TERM_ADD, TERM_ADD, TERM_SUB,
    TERM_ADD, TERM_ADD, TERM_SUB,
    TERM_ADD, TERM_ADD, TERM_SUB
  };

  // Stage two terms, grouped by output component (x, y, z). The conjugate signs
  // are folded into P2_NEG, so the multipliers see q itself.
  localparam logic [1:0] P2_PSEL [NUM_V*P2_TERMS] = '{
    QI_X, QI_Y, QI_Z, QI_W,
    QI_X, QI_Y, QI_Z, QI_W,
    QI_X, QI_Y, QI_Z, QI_W
  };
  localparam logic [1:0] P2_QSEL [NUM_V*P2_TERMS] = '{
    QI_W, QI_Z, QI_Y, QI_X,
    QI_Z, QI_W, QI_X, QI_Y,
    QI_Y, QI_X, QI_W, QI_Z
  };
  localparam logic P2_NEG [NUM_V*P2_TERMS] = '{
    TERM_ADD, TERM_SUB, TERM_ADD, TERM_SUB,
    TERM_ADD, TERM_ADD, TERM_SUB, TERM_SUB,
    TERM_SUB, TERM_ADD, TERM_ADD, TERM_SUB
  };

  // Load enables, one per pipeline stage.
  typedef struct packed {
    logic prod1;
    logic sum1;
    logic prod2;
    logic merge;
    logic sum2;
    logic sat;
  } stage_en_t;

endpackage

@@ hw/rtl/qvr_pipe_ctrl.sv @@
module qvr_pipe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output qvr_pkg::stage_en_t en
);
  import qvr_pkg::*;

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] vld_next;
  logic [NUM_STAGES-1:0] adv;

  // A stage may load when it is empty or its successor loads too.
  always_comb begin
    adv[NUM_STAGES-1] = !vld[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  always_comb begin
    vld_next = vld;
    if (adv[0]) begin
      vld_next[0] = in_valid;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (adv[k]) begin
        vld_next[k] = vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign en.prod1 = adv[ST_PROD1];
  assign en.sum1  = adv[ST_SUM1];
  assign en.prod2 = adv[ST_PROD2];
  assign en.merge = adv[ST_MERGE];
  assign en.sum2  = adv[ST_SUM2];
  assign en.sat   = adv[ST_SAT];

  assign in_stall  = !adv[0];
  assign out_valid = vld[NUM_STAGES-1];

endmodule

@@ hw/rtl/qvr_vec_lift.sv @@
module qvr_vec_lift (
  input  logic               clk,
  input  qvr_pkg::stage_en_t en,
  input  qvr_pkg::quat_t     quat [qvr_pkg::NUM_Q],
  input  qvr_pkg::vec_t      vec [qvr_pkg::NUM_V],
  output qvr_pkg::quat_t     quat_out [qvr_pkg::NUM_Q],
  output qvr_pkg::pval_t     p [qvr_pkg::NUM_Q]
);
  import qvr_pkg::*;

  prod1_t prod [NUM_Q*P1_TERMS];
  quat_t  quat_a [NUM_Q];
  sum1_t  sum [NUM_Q];

  always_ff @(posedge clk) begin
    if (en.prod1) begin
      for (int t = 0; t < NUM_Q * P1_TERMS; t++) begin
        prod[t] <= prod1_t'(quat[P1_QSEL[t]]) * prod1_t'(vec[P1_VSEL[t]]);
      end
      quat_a <= quat;
    end
  end

  // Exact sums, then round half up into the vector format.
  always_comb begin
    sum1_t term;
    for (int c = 0; c < NUM_Q; c++) begin
      sum[c] = HALF1;
      for (int k = 0; k < P1_TERMS; k++) begin
        term = sum1_t'(prod[c*P1_TERMS+k]);
        if (P1_NEG[c*P1_TERMS+k] == TERM_SUB) begin
          sum[c] = sum[c] - term;
        end else begin
          sum[c] = sum[c] + term;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.sum1) begin
      for (int c = 0; c < NUM_Q; c++) begin
        p[c] <= sum[c][SUM1_W-1:QUAT_FRAC_BITS];
      end
      quat_out <= quat_a;
    end
  end

endmodule

@@ hw/rtl/qvr_conj_mul.sv @@
module qvr_conj_mul (
  input  logic               clk,
  input  qvr_pkg::stage_en_t en,
  input  qvr_pkg::quat_t     quat [qvr_pkg::NUM_Q],
  input  qvr_pkg::pval_t     p [qvr_pkg::NUM_Q],
  output qvr_pkg::rval_t     r [qvr_pkg::NUM_V]
);
  import qvr_pkg::*;

  pphi_t  pp_hi [NUM_V*P2_TERMS];
  pplo_t  pp_lo [NUM_V*P2_TERMS];
  prod2_t merged [NUM_V*P2_TERMS];
  sum2_t  sum [NUM_V];

  // Each p component is split into a signed upper half and an unsigned lower
  // half so that no multiplier is wider than the quaternion word.
  always_ff @(posedge clk) begin
    if (en.prod2) begin
      for (int t = 0; t < NUM_V * P2_TERMS; t++) begin
        pp_hi[t] <= pphi_t'($signed(p[P2_PSEL[t]][P_W-1:PLO_W])) *
                    pphi_t'(quat[P2_QSEL[t]]);
        pp_lo[t] <= pplo_t'($signed({1'b0, p[P2_PSEL[t]][PLO_W-1:0]})) *
                    pplo_t'(quat[P2_QSEL[t]]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.merge) begin
      for (int t = 0; t < NUM_V * P2_TERMS; t++) begin
        merged[t] <= (prod2_t'(pp_hi[t]) <<< PLO_W) + prod2_t'(pp_lo[t]);
      end
    end
  end

  always_comb begin
    sum2_t term;
    for (int c = 0; c < NUM_V; c++) begin
      sum[c] = HALF2;
      for (int k = 0; k < P2_TERMS; k++) begin
        term = sum2_t'(merged[c*P2_TERMS+k]);
        if (P2_NEG[c*P2_TERMS+k] == TERM_SUB) begin
          sum[c] = sum[c] - term;
        end else begin
          sum[c] = sum[c] + term;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.sum2) begin
      for (int c = 0; c < NUM_V; c++) begin
        r[c] <= sum[c][SUM2_W-1:QUAT_FRAC_BITS];
      end
    end
  end

endmodule

@@ hw/rtl/qvr_sat.sv @@
module qvr_sat (
  input  logic               clk,
  input  qvr_pkg::stage_en_t en,
  input  qvr_pkg::rval_t     r [qvr_pkg::NUM_V],
  output qvr_pkg::out_t      rot [qvr_pkg::NUM_V],
  output logic               saturated
);
  import qvr_pkg::*;

  out_t rot_next [NUM_V];
  logic clip;

  // A value fits when all bits from the output sign bit upward agree.
  always_comb begin
    logic [R_W-OUT_W:0] hi;
    clip = 1'b0;
    for (int c = 0; c < NUM_V; c++) begin
      hi = r[c][R_W-1:OUT_W-1];
      if ((&hi) || !(|hi)) begin
        rot_next[c] = r[c][OUT_W-1:0];
      end else begin
        clip = 1'b1;
        rot_next[c] = r[c][R_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.sat) begin
      rot       <= rot_next;
      saturated <= clip;
    end
  end

endmodule

@@ hw/rtl/quaternion_vector_rotation.sv @@
// Channel  Handshake            Payload
// input    in_valid / in_stall  quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z
// output   out_valid / out_stall rot_x, rot_y, rot_z, saturated
//
// One item may enter every cycle while in_stall is low. The six register stages,
// in order, are: first products, first sums, split second products, product
// merge, second sums, saturation. Reset clears only the stage valid bits; the
// data registers are not reset. A stall on the output holds the last stage, and
// the stall walks back only as far as the pipeline is full, so empty stages
// still fill behind it.
module quaternion_vector_rotation (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  qvr_pkg::quat_t quat_w,
  input  qvr_pkg::quat_t quat_x,
  input  qvr_pkg::quat_t quat_y,
  input  qvr_pkg::quat_t quat_z,
  input  qvr_pkg::vec_t  vec_x,
  input  qvr_pkg::vec_t  vec_y,
  input  qvr_pkg::vec_t  vec_z,
  output logic           out_valid,
  input  logic           out_stall,
  output qvr_pkg::out_t  rot_x,
  output qvr_pkg::out_t  rot_y,
  output qvr_pkg::out_t  rot_z,
  output logic           saturated
);
  import qvr_pkg::*;

  // Stage load enables shared by all datapath parts.
  stage_en_t en;

  quat_t quat_in [NUM_Q];
  vec_t  vec_in [NUM_V];
  quat_t quat_b [NUM_Q];
  pval_t p [NUM_Q];
  rval_t r [NUM_V];
  out_t  rot [NUM_V];

  assign quat_in[QI_W] = quat_w;
  assign quat_in[QI_X] = quat_x;
  assign quat_in[QI_Y] = quat_y;
  assign quat_in[QI_Z] = quat_z;
  assign vec_in[VI_X]  = vec_x;
  assign vec_in[VI_Y]  = vec_y;
  assign vec_in[VI_Z]  = vec_z;

  // Valid bits and the stall chain live in the controller.
  qvr_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .en        (en)
  );

  // p = q * (0,v), rounded to the vector format. The quaternion travels along
  // with p because the second product needs it two stages later.
  qvr_vec_lift u_lift (
    .clk      (clk),
    .en       (en),
    .quat     (quat_in),
    .vec      (vec_in),
    .quat_out (quat_b),
    .p        (p)
  );

  // Vector part of p * conj(q), rounded the same way but not yet clipped.
  qvr_conj_mul u_conj (
    .clk  (clk),
    .en   (en),
    .quat (quat_b),
    .p    (p),
    .r    (r)
  );

  // Clip each component to 32 bits and flag any clipping; this is the output register.
  qvr_sat u_sat (
    .clk       (clk),
    .en        (en),
    .r         (r),
    .rot       (rot),
    .saturated (saturated)
  );

  assign rot_x = rot[VI_X];
  assign rot_y = rot[VI_Y];
  assign rot_z = rot[VI_Z];

endmodule

@@ hw/rtl/qvr_checker.sv @@
`include "assert_macros.svh"

module qvr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] rot_x,
  input logic [31:0] rot_y,
  input logic [31:0] rot_z,
  input logic        saturated
);

  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  logic        out_held;
  logic [96:0] out_word;
  logic        at_limit;

  assign out_held = out_valid && out_stall;
  assign out_word = {rot_x, rot_y, rot_z, saturated};
  assign at_limit = rot_x == SAT_MAX || rot_x == SAT_MIN ||
                    rot_y == SAT_MAX || rot_y == SAT_MIN ||
                    rot_z == SAT_MAX || rot_z == SAT_MIN;

  // A held result keeps its values.
  `QVR_ASSERT_NEXT(a_out_hold, clk, rst, out_held, out_valid && $stable(out_word))

  // The input stalls only when the whole pipeline is full behind a stalled output.
  `QVR_ASSERT_IMP(a_stall_full, clk, rst, in_stall, out_held)

  // A clipped result has at least one component at an end of the range.
  `QVR_ASSERT_IMP(a_clip_value, clk, rst, out_valid && saturated, at_limit)

  // Reset empties the pipeline.
  `QVR_ASSERT_IMP(a_reset_empty, clk, 1'b0, $past(rst), !out_valid && !in_stall)

endmodule

bind quaternion_vector_rotation qvr_checker u_qvr_checker (.*);
